// ----- src/dcm_pkg.sv -----
// Shared types and constants for the duty cycle meter.
package dcm_pkg;

	// Width of the timestamp field on the input port
	localparam int NOW_W = 64;

	// Default width of the timer that is actually measured
	localparam int TIME_BITS_DEF = 64;

	// Result width and full-scale value (one million ppm)
	localparam int PPM_W = 20;
	localparam logic [PPM_W-1:0] PPM_FULL = 20'd1000000;

	// Command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_RESET = 2'd2,
		CMD_QUERY = 2'd3
	} dcm_cmd_t;

endpackage

// ----- src/dcm_front.sv -----
// Command front end: owns the meter state and turns queries into division jobs.
module dcm_front #(
	parameter int TIME_BITS = dcm_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [dcm_pkg::NOW_W-1:0]  now,
	output logic                       push,
	output logic [2*TIME_BITS:0]       push_data,
	input  logic                       full
);
	import dcm_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIFF,
		F_SUM,
		F_PUSH
	} f_state_t;

	f_state_t               state_q;
	dcm_cmd_t               cmd_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   run_start_q;
	logic [TIME_BITS-1:0]   active_total_q;
	logic [TIME_BITS-1:0]   window_start_q;
	logic [TIME_BITS-1:0]   run_q;
	logic [TIME_BITS-1:0]   span_q;
	logic [TIME_BITS:0]     act_q;
	logic                   sat;

	// One transaction in flight in the front end
	assign in_stall = (state_q != F_IDLE);

	// Saturate on an empty window or when active time reaches the window length
	assign sat       = (span_q == '0) || (act_q >= {1'b0, span_q});
	assign push      = (state_q == F_PUSH) && !full;
	assign push_data = {sat, act_q[TIME_BITS-1:0], span_q};

	// Command sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			cmd_q          <= CMD_START;
			now_q          <= '0;
			run_start_q    <= '0;
			active_total_q <= '0;
			window_start_q <= '0;
			run_q          <= '0;
			span_q         <= '0;
			act_q          <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						cmd_q   <= dcm_cmd_t'(cmd);
						now_q   <= now[TIME_BITS-1:0];
						state_q <= F_DIFF;
					end
				end
				F_DIFF: begin
					unique case (cmd_q)
						CMD_START: begin
							// a start while running keeps the first start time
							if (run_start_q == '0) begin
								run_start_q <= now_q;
							end
							state_q <= F_IDLE;
						end
						CMD_RESET: begin
							run_start_q    <= '0;
							active_total_q <= '0;
							window_start_q <= now_q;
							state_q        <= F_IDLE;
						end
						CMD_STOP, CMD_QUERY: begin
							// running interval, zero when not running
							run_q   <= (run_start_q != '0) ? (now_q - run_start_q) : '0;
							span_q  <= now_q - window_start_q;
							state_q <= F_SUM;
						end
					endcase
				end
				F_SUM: begin
					if (cmd_q == CMD_STOP) begin
						active_total_q <= active_total_q + run_q;
						run_start_q    <= '0;
						state_q        <= F_IDLE;
					end else begin
						// keep the carry so an overflowing sum still saturates
						act_q   <= {1'b0, active_total_q} + {1'b0, run_q};
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/dcm_queue.sv -----
// Two-entry job queue between the front end and the divider.
module dcm_queue #(
	parameter int DATA_W = 2 * dcm_pkg::TIME_BITS_DEF + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/dcm_back.sv -----
// Back end: shift-add scaling by one million, restoring division, result register.
module dcm_back #(
	parameter int TIME_BITS = dcm_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  logic [2*TIME_BITS:0]          job_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dcm_pkg::PPM_W-1:0]     duty_ppm
);
	import dcm_pkg::*;

	localparam int PROD_W = TIME_BITS + PPM_W;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_DONE
	} b_state_t;

	b_state_t             state_q;
	logic [TIME_BITS-1:0] act_q;
	logic [TIME_BITS-1:0] span_q;
	logic [PROD_W-1:0]    prod_q;
	logic [4:0]           cnt_q;
	logic                 out_valid_q;
	logic [PPM_W-1:0]     duty_ppm_q;

	logic [TIME_BITS:0]   cand;
	logic [TIME_BITS:0]   diff;
	logic                 ge;
	logic [TIME_BITS-1:0] new_rem;
	logic                 load_out;

	assign pop       = (state_q == B_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign duty_ppm  = duty_ppm_q;

	// Result register takes a new value once the previous one has left
	assign load_out = (state_q == B_DONE) && (!out_valid_q || !out_stall);

	// One divider step: remainder sits above the quotient bits in prod_q
	assign cand    = {prod_q[PROD_W-1:PPM_W], prod_q[PPM_W-1]};
	assign diff    = cand - {1'b0, span_q};
	assign ge      = (cand >= {1'b0, span_q});
	assign new_rem = ge ? diff[TIME_BITS-1:0] : cand[TIME_BITS-1:0];

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			act_q       <= '0;
			span_q      <= '0;
			prod_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			duty_ppm_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						act_q  <= job_data[2*TIME_BITS-1:TIME_BITS];
						span_q <= job_data[TIME_BITS-1:0];
						cnt_q  <= 5'(PPM_W - 1);
						if (job_data[2*TIME_BITS]) begin
							// saturated: full scale straight to the output
							prod_q  <= {{TIME_BITS{1'b0}}, PPM_FULL};
							state_q <= B_DONE;
						end else begin
							prod_q  <= '0;
							state_q <= B_MUL;
						end
					end
				end
				B_MUL: begin
					// MSB first over the bits of one million
					prod_q <= {prod_q[PROD_W-2:0], 1'b0}
						+ (PPM_FULL[cnt_q] ? {{PPM_W{1'b0}}, act_q} : {PROD_W{1'b0}});
					if (cnt_q == '0) begin
						cnt_q   <= 5'(PPM_W - 1);
						state_q <= B_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				B_DIV: begin
					// remainder stays below span, quotient shifts in at the bottom
					prod_q <= {new_rem, prod_q[PPM_W-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				B_DONE: begin
					if (load_out) begin
						duty_ppm_q <= prod_q[PPM_W-1:0];
						state_q    <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/duty_cycle_meter_unit.sv -----
// Duty cycle meter top level: front end, job queue and divider back end.
//
// Commands are start, stop, reset and query, each with the current timer value; only
// query returns a result, the active time since the last reset as parts per million of
// the window, saturated at 1000000 (also for an empty window). A start at time zero
// reads as not running. The front end takes one transaction at a time: start and reset
// occupy it for the capture and decode states, stop also for the summing state, query
// for those and the push state plus any wait for queue space. Each query then passes
// the back end as 1 load, 20 shift-add steps scaling by one million, 20 restoring-division
// steps and 1 output, or load straight to output when saturated; this one-bit-per-cycle
// multiply and divide unit sets the sustained query rate. A two-entry queue lets the front
// end keep taking commands while the back end divides and while a result waits in the output register.
module duty_cycle_meter_unit #(
	parameter int TIME_BITS = dcm_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [dcm_pkg::NOW_W-1:0]  now,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [dcm_pkg::PPM_W-1:0]  duty_ppm
);
	import dcm_pkg::*;

	localparam int JOB_W = 2 * TIME_BITS + 1;

	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             full;
	logic             pop;
	logic [JOB_W-1:0] pop_data;
	logic             empty;

	// Command handling and meter state
	dcm_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.now       (now),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Query jobs waiting for the divider
	dcm_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Scaling, division and result register
	dcm_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty_ppm  (duty_ppm)
	);

endmodule

// ----- sim/duty_cycle_meter_unit_test.sv -----
// Self-checking testbench for the duty cycle meter: directed corner cases, then random command sessions.
module duty_cycle_meter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dcm_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1000;
	localparam int TOTAL_ITEMS = 1150;

	// Tracks meter state and holds the duty readings still owed by the block
	class duty_scoreboard;
		logic [63:0] run_start = '0;
		logic [63:0] active_total = '0;
		logic [63:0] window_start = '0;
		logic [PPM_W-1:0] pending_ppm[$];
		int errors = 0;
		int queries_checked = 0;
		int saturated = 0;

		// Apply one accepted command transaction to the state
		function void note_command(dcm_cmd_t op, logic [63:0] t);
			logic [63:0] span;
			logic [64:0] act;
			logic [127:0] wide_num;
			logic [127:0] wide_den;
			logic [127:0] quot;
			logic [PPM_W-1:0] ppm;
			case (op)
				CMD_START: begin
					if (run_start == '0)
						run_start = t;
				end
				CMD_STOP: begin
					if (run_start != '0) begin
						active_total = active_total + (t - run_start);
						run_start = '0;
					end
				end
				CMD_RESET: begin
					run_start = '0;
					active_total = '0;
					window_start = t;
				end
				default: begin
					span = t - window_start;
					act = {1'b0, active_total};
					// running interval counts too; carry out means overflow past 64 bits
					if (run_start != '0)
						act = act + {1'b0, t - run_start};
					if (span == '0 || act >= {1'b0, span}) begin
						ppm = PPM_FULL;
					end else begin
						wide_num = {64'd0, act[63:0]};
						wide_den = {64'd0, span};
						quot = (wide_num * 128'd1000000) / wide_den;
						ppm = quot[PPM_W-1:0];
					end
					pending_ppm.push_back(ppm);
				end
			endcase
		endfunction

		// Compare one accepted result transaction with the oldest expectation
		function void check_ppm(logic [PPM_W-1:0] got);
			logic [PPM_W-1:0] want;
			if (pending_ppm.size() == 0) begin
				$display("%0t: unexpected duty_ppm %0d with nothing pending", $time, got);
				errors++;
			end else begin
				want = pending_ppm.pop_front();
				queries_checked++;
				if (want == PPM_FULL)
					saturated++;
				if (got !== want) begin
					$display("%0t: duty_ppm mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return pending_ppm.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [NOW_W-1:0] now = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PPM_W-1:0] duty_ppm;

	duty_scoreboard sb = new();
	int items_sent = 0;
	int cycle_count = 0;
	bit jitter_on = 1'b1;
	bit long_hold = 1'b0;

	duty_cycle_meter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.now(now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_ppm(duty_ppm)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d readings outstanding.",
				cycle_count, sb.outstanding());
			$display("status: fail");
			$finish;
		end
	end

	// Observe accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_command(dcm_cmd_t'(cmd), now);
		if (arst_n && out_valid && !out_stall)
			sb.check_ppm(duty_ppm);
	end

	// Result side: random stall bursts, plus one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (jitter_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one command transaction and hold it until taken
	task automatic send_item(dcm_cmd_t op, logic [63:0] t);
		if (jitter_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		now <= t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	// Time step between commands, from zero ticks up to a full wrap
	function automatic logic [63:0] next_gap();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return {32'd0, 32'($urandom_range(0, 50))};
			4, 5: return {32'd0, 32'($urandom_range(0, 100000))};
			6: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One measurement window: reset, then start/stop/query at rising times
	task automatic run_session();
		logic [63:0] t;
		bit running;
		dcm_cmd_t op;
		if ($urandom_range(0, 1))
			t = {$urandom, $urandom};
		else
			t = {32'd0, 32'($urandom_range(0, 100000))};
		send_item(CMD_RESET, t);
		running = 1'b0;
		repeat ($urandom_range(3, 12)) begin
			t = t + next_gap();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = CMD_QUERY;
				4: op = running ? CMD_START : CMD_STOP;
				default: op = running ? CMD_STOP : CMD_START;
			endcase
			if (op == CMD_START && !running)
				running = (t != '0);
			else if (op == CMD_STOP)
				running = 1'b0;
			send_item(op, t);
		end
	endtask

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty window at time zero, lost start at zero, stray stop
		send_item(CMD_QUERY, 64'd0);
		send_item(CMD_START, 64'd0);
		send_item(CMD_QUERY, 64'd1000);
		send_item(CMD_STOP, 64'd2000);
		// ordinary window with a repeated start
		send_item(CMD_RESET, 64'd5000);
		send_item(CMD_START, 64'd6000);
		send_item(CMD_START, 64'd7000);
		send_item(CMD_QUERY, 64'd9000);
		send_item(CMD_STOP, 64'd10000);
		send_item(CMD_QUERY, 64'd15000);
		// timer wrap inside the window and inside the interval
		send_item(CMD_RESET, 64'hFFFF_FFFF_FFFF_FF00);
		send_item(CMD_START, 64'hFFFF_FFFF_FFFF_FF80);
		send_item(CMD_QUERY, 64'h80);
		send_item(CMD_STOP, 64'h100);
		send_item(CMD_QUERY, 64'h200);
		// active time longer than the window
		send_item(CMD_RESET, 64'd100);
		send_item(CMD_START, 64'd50);
		send_item(CMD_QUERY, 64'd200);
		// active total plus running interval overflows 64 bits
		send_item(CMD_RESET, 64'd10);
		send_item(CMD_START, 64'd20);
		send_item(CMD_STOP, 64'd19);
		send_item(CMD_START, 64'd30);
		send_item(CMD_QUERY, 64'd40);
		// all-ones timestamp
		send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);

		// random sessions with some noise, one long output hold midway
		while (items_sent < RANDOM_ITEMS) begin
			if (!hold_done && items_sent >= 400) begin
				hold_done = 1'b1;
				long_hold = 1'b1;
				repeat (12) send_item(CMD_QUERY, {$urandom, $urandom});
			end
			if ($urandom_range(0, 6) == 0)
				send_item(dcm_cmd_t'($urandom_range(0, 3)), {$urandom, $urandom});
			else
				run_session();
		end

		// closing stretch at full rate on both sides
		jitter_on = 1'b0;
		while (items_sent < TOTAL_ITEMS)
			run_session();
		in_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d commands over random windows with wrap, overflow and empty-window cases.",
			items_sent);
		$display("Checked %0d duty readings, %0d of them at full scale.",
			sb.queries_checked, sb.saturated);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
